FILE: rtl/tgcw_pkg.sv
// Shared types and constants of the text grid cursor writer.
package tgcw_pkg;

   // Widths fixed by the command and result word formats.
   localparam int SIZE_W = 9;
   localparam int CUR_W  = 10;

   // Command kinds.
   localparam logic [2:0] KIND_WRITE  = 3'd0;
   localparam logic [2:0] KIND_MOVE   = 3'd1;
   localparam logic [2:0] KIND_CLEAR  = 3'd2;
   localparam logic [2:0] KIND_RESIZE = 3'd3;
   localparam logic [2:0] KIND_READ   = 3'd4;

   // Character codes.
   localparam logic [31:0] NEWLINE_CODE = 32'd10;
   localparam logic [31:0] BLANK_RESET  = 32'd32;

   // Description of one blanking pass over the store.
   typedef struct packed {
      logic              all;    // blank every visited cell
      logic [SIZE_W-1:0] cols;   // columns visited, at least 1
      logic [SIZE_W-1:0] rows;   // rows visited, at least 1
      logic [SIZE_W-1:0] old_w;
      logic [SIZE_W-1:0] old_h;
      logic [SIZE_W-1:0] new_w;
      logic [SIZE_W-1:0] new_h;
   } sweep_cmd_type;

endpackage

FILE: rtl/tgcw_store.sv
// Character cell memory: one write port, one registered read port.
module tgcw_store #(
   parameter int ROW_BITS = 6,
   parameter int COL_BITS = 7
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ROW_BITS-1:0] wr_row,
   input  logic [COL_BITS-1:0] wr_col,
   input  logic [31:0]         wr_data,
   input  logic                rd_en,
   input  logic [ROW_BITS-1:0] rd_row,
   input  logic [COL_BITS-1:0] rd_col,
   output logic [31:0]         rd_data
);

   localparam int DEPTH = 2 ** (ROW_BITS + COL_BITS);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{wr_row, wr_col}] <= wr_data;
      end
   end

   // Read port with a registered output.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[{rd_row, rd_col}];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tgcw_sweep.sv
// Walks a store rectangle one cell per cycle and blanks the chosen cells.
module tgcw_sweep #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  tgcw_pkg::sweep_cmd_type cmd,
   output logic                   busy,
   output logic                   wr_en,
   output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] wr_row,
   output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] wr_col
);

   localparam int ROW_BITS = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_BITS = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam logic [tgcw_pkg::SIZE_W-1:0] COLS_FULL = tgcw_pkg::SIZE_W'(MAX_COLS);
   localparam logic [tgcw_pkg::SIZE_W-1:0] ROWS_FULL = tgcw_pkg::SIZE_W'(MAX_ROWS);

   logic                    active_ff, active_in;
   logic [ROW_BITS-1:0]     row_ff, row_in;
   logic [COL_BITS-1:0]     col_ff, col_in;
   tgcw_pkg::sweep_cmd_type cmd_ff, cmd_in;

   logic [tgcw_pkg::SIZE_W-1:0] row9, col9;
   logic                        last_col, last_row, hit;

   // Position tests on the current cell.
   always_comb begin
      row9     = tgcw_pkg::SIZE_W'(row_ff);
      col9     = tgcw_pkg::SIZE_W'(col_ff);
      last_col = (col9 == cmd_ff.cols - 9'd1);
      last_row = (row9 == cmd_ff.rows - 9'd1);
      hit      = cmd_ff.all
               || ((row9 >= cmd_ff.old_h) && (row9 < cmd_ff.new_h))
               || ((col9 >= cmd_ff.old_w) && (col9 < cmd_ff.new_w));
   end

   // Row-major walk over the rectangle.
   always_comb begin
      active_in = active_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      cmd_in    = cmd_ff;
      if (start) begin
         active_in = 1'b1;
         row_in    = '0;
         col_in    = '0;
         cmd_in    = cmd;
      end else if (active_ff) begin
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               active_in = 1'b0;
            end else begin
               row_in = row_ff + ROW_BITS'(1);
            end
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   // After reset the whole store is walked once.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b1;
         row_ff      <= '0;
         col_ff      <= '0;
         cmd_ff.all  <= 1'b1;
         cmd_ff.cols <= COLS_FULL;
         cmd_ff.rows <= ROWS_FULL;
         cmd_ff.old_w <= '0;
         cmd_ff.old_h <= '0;
         cmd_ff.new_w <= '0;
         cmd_ff.new_h <= '0;
      end else begin
         active_ff <= active_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         cmd_ff    <= cmd_in;
      end
   end

   assign busy   = active_ff;
   assign wr_en  = active_ff && hit;
   assign wr_row = row_ff;
   assign wr_col = col_ff;

endmodule

FILE: rtl/text_grid_cursor_writer.sv
// Top level of the text grid cursor writer: command decode, cursor and size registers.
// Write, move and undefined commands never raise busy; the result word follows in the next cycle.
// Read waits in ST_READ for the registered store read data, then registers the result word.
// Clear and resize walk one cell per cycle while busy is high: clear walks and writes all
// MAX_ROWS*MAX_COLS cells, resize walks the new stored grid and writes only its new cells.
// After reset busy stays high while the whole store is blanked.
// Every result word is shown for one cycle on rsp_strobe; the receiver cannot stall.
module text_grid_cursor_writer #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_kind,
   input  logic [31:0]        req_char_code,
   input  logic [7:0]         req_col,
   input  logic [7:0]         req_row,
   output logic               rsp_strobe,
   output logic               rsp_accepted,
   output logic [31:0]        rsp_cell_value,
   output logic signed [9:0]  rsp_cursor_col_now,
   output logic signed [9:0]  rsp_cursor_row_now,
   input  logic               csr_write_enable,
   input  logic [31:0]        csr_write_data
);

   localparam int ROW_BITS = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_BITS = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam logic [tgcw_pkg::SIZE_W-1:0] COLS_FULL = tgcw_pkg::SIZE_W'(MAX_COLS);
   localparam logic [tgcw_pkg::SIZE_W-1:0] ROWS_FULL = tgcw_pkg::SIZE_W'(MAX_ROWS);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_READ  = 3'b010,
      ST_SWEEP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] blank_ff;
   logic [31:0] fill_ff, fill_in;
   logic [tgcw_pkg::SIZE_W-1:0] lw_ff, lw_in, lh_ff, lh_in;
   logic [tgcw_pkg::CUR_W-1:0]  cur_col_ff, cur_col_in, cur_row_ff, cur_row_in;
   logic        read_ok_ff, read_ok_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   logic        rsp_accepted_ff, rsp_accepted_in;
   logic [31:0] rsp_cell_ff, rsp_cell_in;

   logic accept;
   logic [tgcw_pkg::SIZE_W-1:0] sw, sh, new_w, new_h;
   logic [tgcw_pkg::CUR_W-1:0]  col_inc, lw_m1, lh_m1, move_col, move_row;
   logic cur_in_grid, rd_in_grid;

   // Command side of the store ports.
   logic                cmd_wr_en, cmd_rd_en;
   logic                mem_wr_en;
   logic [ROW_BITS-1:0] mem_wr_row;
   logic [COL_BITS-1:0] mem_wr_col;
   logic [31:0]         mem_wr_data;
   logic [31:0]         mem_rd_data;

   // Blanking walker.
   logic                    sweep_start;
   tgcw_pkg::sweep_cmd_type sweep_cmd;
   logic                    sweep_busy, sweep_wr_en;
   logic [ROW_BITS-1:0]     sweep_wr_row;
   logic [COL_BITS-1:0]     sweep_wr_col;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Stored grid size and cursor tests.
   always_comb begin
      sw          = (lw_ff == '0) ? 9'd1 : lw_ff;
      sh          = (lh_ff == '0) ? 9'd1 : lh_ff;
      cur_in_grid = !cur_col_ff[tgcw_pkg::CUR_W-1] && !cur_row_ff[tgcw_pkg::CUR_W-1]
                 && (cur_col_ff < {1'b0, sw}) && (cur_row_ff < {1'b0, sh});
      rd_in_grid  = ({1'b0, req_col} < sw) && ({1'b0, req_row} < sh);
      col_inc     = cur_col_ff + 10'd1;
      lw_m1       = {1'b0, lw_ff} - 10'd1;
      lh_m1       = {1'b0, lh_ff} - 10'd1;
      move_col    = ($signed(lw_m1) < $signed({2'b00, req_col})) ? lw_m1 : {2'b00, req_col};
      move_row    = ($signed(lh_m1) < $signed({2'b00, req_row})) ? lh_m1 : {2'b00, req_row};
      new_w       = ({1'b0, req_col} > COLS_FULL) ? COLS_FULL : {1'b0, req_col};
      new_h       = ({1'b0, req_row} > ROWS_FULL) ? ROWS_FULL : {1'b0, req_row};
   end

   // Command decode.
   always_comb begin
      state_in        = state_ff;
      fill_in         = fill_ff;
      lw_in           = lw_ff;
      lh_in           = lh_ff;
      cur_col_in      = cur_col_ff;
      cur_row_in      = cur_row_ff;
      read_ok_in      = read_ok_ff;
      rsp_strobe_in   = 1'b0;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_cell_in     = rsp_cell_ff;
      cmd_wr_en       = 1'b0;
      cmd_rd_en       = 1'b0;
      sweep_start     = 1'b0;
      sweep_cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_strobe_in   = 1'b1;
               rsp_accepted_in = 1'b0;
               rsp_cell_in     = '0;
               case (req_kind)
                  tgcw_pkg::KIND_WRITE: begin
                     if (cur_in_grid) begin
                        rsp_accepted_in = 1'b1;
                        if (req_char_code == tgcw_pkg::NEWLINE_CODE) begin
                           cur_col_in = '0;
                           cur_row_in = cur_row_ff + 10'd1;
                        end else begin
                           cmd_wr_en = 1'b1;
                           if (col_inc == {1'b0, sw}) begin
                              cur_col_in = '0;
                              cur_row_in = cur_row_ff + 10'd1;
                           end else begin
                              cur_col_in = col_inc;
                           end
                        end
                     end
                  end
                  tgcw_pkg::KIND_MOVE: begin
                     rsp_accepted_in = 1'b1;
                     cur_col_in      = move_col;
                     cur_row_in      = move_row;
                  end
                  tgcw_pkg::KIND_CLEAR: begin
                     rsp_accepted_in = 1'b1;
                     cur_col_in      = '0;
                     cur_row_in      = '0;
                     fill_in         = blank_ff;
                     sweep_start     = 1'b1;
                     sweep_cmd.all   = 1'b1;
                     sweep_cmd.cols  = COLS_FULL;
                     sweep_cmd.rows  = ROWS_FULL;
                     state_in        = ST_SWEEP;
                  end
                  tgcw_pkg::KIND_RESIZE: begin
                     rsp_accepted_in = 1'b1;
                     lw_in           = new_w;
                     lh_in           = new_h;
                     fill_in         = blank_ff;
                     sweep_start     = 1'b1;
                     sweep_cmd.all   = 1'b0;
                     sweep_cmd.cols  = (new_w == '0) ? 9'd1 : new_w;
                     sweep_cmd.rows  = (new_h == '0) ? 9'd1 : new_h;
                     sweep_cmd.old_w = lw_ff;
                     sweep_cmd.old_h = lh_ff;
                     sweep_cmd.new_w = new_w;
                     sweep_cmd.new_h = new_h;
                     state_in        = ST_SWEEP;
                  end
                  tgcw_pkg::KIND_READ: begin
                     // The result word waits for the memory read data.
                     rsp_strobe_in = 1'b0;
                     cmd_rd_en     = 1'b1;
                     read_ok_in    = rd_in_grid;
                     state_in      = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_strobe_in   = 1'b1;
            rsp_accepted_in = read_ok_ff;
            rsp_cell_in     = read_ok_ff ? mem_rd_data : '0;
            state_in        = ST_IDLE;
         end
         ST_SWEEP: begin
            if (!sweep_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Store write port: the walker owns it while a blanking pass runs.
   always_comb begin
      if (state_ff == ST_SWEEP) begin
         mem_wr_en   = sweep_wr_en;
         mem_wr_row  = sweep_wr_row;
         mem_wr_col  = sweep_wr_col;
         mem_wr_data = fill_ff;
      end else begin
         mem_wr_en   = cmd_wr_en;
         mem_wr_row  = cur_row_ff[ROW_BITS-1:0];
         mem_wr_col  = cur_col_ff[COL_BITS-1:0];
         mem_wr_data = req_char_code;
      end
   end

   // Control and state registers; reset starts the blanking pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         blank_ff      <= tgcw_pkg::BLANK_RESET;
         fill_ff       <= tgcw_pkg::BLANK_RESET;
         lw_ff         <= 9'd1;
         lh_ff         <= 9'd1;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         lw_ff         <= lw_in;
         lh_ff         <= lh_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            blank_ff <= csr_write_data;
         end
      end
   end

   // Result word payload.
   always_ff @(posedge clock) begin
      read_ok_ff      <= read_ok_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_cell_ff     <= rsp_cell_in;
   end

   tgcw_store #(
      .ROW_BITS (ROW_BITS),
      .COL_BITS (COL_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_row  (mem_wr_row),
      .wr_col  (mem_wr_col),
      .wr_data (mem_wr_data),
      .rd_en   (cmd_rd_en),
      .rd_row  (req_row[ROW_BITS-1:0]),
      .rd_col  (req_col[COL_BITS-1:0]),
      .rd_data (mem_rd_data)
   );

   tgcw_sweep #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_sweep (
      .clock  (clock),
      .reset  (reset),
      .start  (sweep_start),
      .cmd    (sweep_cmd),
      .busy   (sweep_busy),
      .wr_en  (sweep_wr_en),
      .wr_row (sweep_wr_row),
      .wr_col (sweep_wr_col)
   );

   // The cursor registers already hold the post-command value while the word is shown.
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_accepted       = rsp_accepted_ff;
   assign rsp_cell_value     = rsp_cell_ff;
   assign rsp_cursor_col_now = $signed(cur_col_ff);
   assign rsp_cursor_row_now = $signed(cur_row_ff);

endmodule
